FILE: rtl/vt100_escape_sequence_parser_core_assert.svh
// Assertion macros for the escape sequence parser
`ifndef VT100_ESCAPE_SEQUENCE_PARSER_CORE_ASSERT_SVH
`define VT100_ESCAPE_SEQUENCE_PARSER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define VTESC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vtesc assertion failed");
`define VTESC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtesc assertion failed");
`else
`define VTESC_ASSERT(lbl, clk, rst, prop)
`define VTESC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/vtesc_pkg.sv
// Shared types, codes and decode tables of the escape sequence parser
`timescale 1ns / 1ps
package vtesc_pkg;
  localparam int PARAM_DEPTH_DEF = 16;
  localparam int OUT_PARAMS_MAX  = 16;

  // command codes
  localparam logic [5:0] CMD_PRINT = 6'd0,  CMD_ACK = 6'd1,   CMD_ENQ = 6'd2;
  localparam logic [5:0] CMD_BEL = 6'd3,    CMD_HT = 6'd4,    CMD_BS = 6'd5;
  localparam logic [5:0] CMD_LF = 6'd6,     CMD_CR = 6'd7,    CMD_XON = 6'd8;
  localparam logic [5:0] CMD_XOFF = 6'd9,   CMD_SI = 6'd10,   CMD_SO = 6'd11;
  localparam logic [5:0] CMD_DECSC = 6'd12, CMD_DECRC = 6'd13, CMD_RIS = 6'd14;
  localparam logic [5:0] CMD_IND = 6'd15,   CMD_NEL = 6'd16,  CMD_HTS = 6'd17;
  localparam logic [5:0] CMD_RI = 6'd18,    CMD_DECID = 6'd19, CMD_KPAM = 6'd20;
  localparam logic [5:0] CMD_KPNM = 6'd21,  CMD_ANSI = 6'd22, CMD_CUU = 6'd23;
  localparam logic [5:0] CMD_CUD = 6'd24,   CMD_CUF = 6'd25,  CMD_CUB = 6'd26;
  localparam logic [5:0] CMD_GFX_ON = 6'd27, CMD_GFX_OFF = 6'd28, CMD_CUP = 6'd29;
  localparam logic [5:0] CMD_ED = 6'd30,    CMD_EL = 6'd31,   CMD_VT52ID = 6'd32;
  localparam logic [5:0] CMD_G0 = 6'd33,    CMD_G1 = 6'd34,   CMD_DECLL = 6'd35;
  localparam logic [5:0] CMD_STBM = 6'd36,  CMD_TST = 6'd37,  CMD_SGR = 6'd38;
  localparam logic [5:0] CMD_DSR = 6'd39,   CMD_REPT = 6'd40, CMD_TBC = 6'd41;
  localparam logic [5:0] CMD_SM = 6'd42,    CMD_RM = 6'd43,   CMD_DHL_T = 6'd44;
  localparam logic [5:0] CMD_DHL_B = 6'd45, CMD_SWL = 6'd46,  CMD_DWL = 6'd47;
  localparam logic [5:0] CMD_ALN = 6'd48,   CMD_PRM = 6'd49,  CMD_PSM = 6'd50;
  localparam logic [5:0] CMD_NONE = 6'h3F;
  localparam logic [7:0] CS_NONE  = 8'hFF;

  // operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_MODE = 1'b1;

  // characters
  localparam logic [7:0] CH_ESC = 8'h1B, CH_CAN = 8'h18, CH_SUB = 8'h1A;
  localparam logic [7:0] CH_DEL = 8'h7F, CH_SPACE = 8'h20, CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0 = 8'h30, CH_9 = 8'h39, CH_Q = 8'h3F;
  localparam logic [7:0] CH_ABORT_GLYPH = 8'd176;

  typedef enum logic [3:0] {
    PS_GROUND = 4'd0, PS_ESC = 4'd1, PS_CSI = 4'd2, PS_CSIQ = 4'd3, PS_HASH = 4'd4,
    PS_G0 = 4'd5, PS_G1 = 4'd6, PS_ESCO = 4'd7, PS_CDA = 4'd8
  } ps_t;

  typedef enum logic {BK_IDLE, BK_BUSY} bk_state_t;

  // one decoded command waiting for the back end
  typedef struct packed {
    logic [5:0] cmd;
    logic [7:0] arg;
    logic [4:0] n;
  } desc_t;

  // store write from front end
  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [15:0] data;
  } wr_t;

  function automatic logic [5:0] ctrl_cmd(input logic [7:0] b);
    case (b)
      8'h03: ctrl_cmd = CMD_ACK;
      8'h05: ctrl_cmd = CMD_ENQ;
      8'h07: ctrl_cmd = CMD_BEL;
      8'h09: ctrl_cmd = CMD_HT;
      8'h08: ctrl_cmd = CMD_BS;
      8'h0A, 8'h0B, 8'h0C: ctrl_cmd = CMD_LF;
      8'h0D: ctrl_cmd = CMD_CR;
      8'h11: ctrl_cmd = CMD_XON;
      8'h13: ctrl_cmd = CMD_XOFF;
      8'h0F: ctrl_cmd = CMD_SI;
      8'h0E: ctrl_cmd = CMD_SO;
      default: ctrl_cmd = CMD_NONE;
    endcase
  endfunction

  function automatic logic [5:0] esc_ansi_cmd(input logic [7:0] b);
    case (b)
      "7": esc_ansi_cmd = CMD_DECSC;
      "8": esc_ansi_cmd = CMD_DECRC;
      "c": esc_ansi_cmd = CMD_RIS;
      "D": esc_ansi_cmd = CMD_IND;
      "E": esc_ansi_cmd = CMD_NEL;
      "H": esc_ansi_cmd = CMD_HTS;
      "M": esc_ansi_cmd = CMD_RI;
      "Z": esc_ansi_cmd = CMD_DECID;
      "=": esc_ansi_cmd = CMD_KPAM;
      ">": esc_ansi_cmd = CMD_KPNM;
      default: esc_ansi_cmd = CMD_NONE;
    endcase
  endfunction

  function automatic logic [5:0] esc_vt52_cmd(input logic [7:0] b);
    case (b)
      "=": esc_vt52_cmd = CMD_KPAM;
      ">": esc_vt52_cmd = CMD_KPNM;
      "<": esc_vt52_cmd = CMD_ANSI;
      "A": esc_vt52_cmd = CMD_CUU;
      "B": esc_vt52_cmd = CMD_CUD;
      "C": esc_vt52_cmd = CMD_CUF;
      "D": esc_vt52_cmd = CMD_CUB;
      "F": esc_vt52_cmd = CMD_GFX_ON;
      "G": esc_vt52_cmd = CMD_GFX_OFF;
      "H": esc_vt52_cmd = CMD_CUP;
      "I": esc_vt52_cmd = CMD_RI;
      "J": esc_vt52_cmd = CMD_ED;
      "K": esc_vt52_cmd = CMD_EL;
      "Z": esc_vt52_cmd = CMD_VT52ID;
      default: esc_vt52_cmd = CMD_NONE;
    endcase
  endfunction

  function automatic logic [5:0] csi_cmd(input logic [7:0] b);
    case (b)
      "A": csi_cmd = CMD_CUU;
      "B": csi_cmd = CMD_CUD;
      "C": csi_cmd = CMD_CUF;
      "D": csi_cmd = CMD_CUB;
      "H", "f": csi_cmd = CMD_CUP;
      "c": csi_cmd = CMD_DECID;
      "q": csi_cmd = CMD_DECLL;
      "r": csi_cmd = CMD_STBM;
      "y": csi_cmd = CMD_TST;
      "J": csi_cmd = CMD_ED;
      "K": csi_cmd = CMD_EL;
      "m": csi_cmd = CMD_SGR;
      "n": csi_cmd = CMD_DSR;
      "x": csi_cmd = CMD_REPT;
      "g": csi_cmd = CMD_TBC;
      "h": csi_cmd = CMD_SM;
      "l": csi_cmd = CMD_RM;
      default: csi_cmd = CMD_NONE;
    endcase
  endfunction

  function automatic logic [5:0] hash_cmd(input logic [7:0] b);
    case (b)
      "3": hash_cmd = CMD_DHL_T;
      "4": hash_cmd = CMD_DHL_B;
      "5": hash_cmd = CMD_SWL;
      "6": hash_cmd = CMD_DWL;
      "8": hash_cmd = CMD_ALN;
      default: hash_cmd = CMD_NONE;
    endcase
  endfunction

  function automatic logic [7:0] charset_num(input logic [7:0] b);
    case (b)
      "A": charset_num = 8'd0;
      "B": charset_num = 8'd1;
      "0": charset_num = 8'd2;
      "1": charset_num = 8'd3;
      "2": charset_num = 8'd4;
      default: charset_num = CS_NONE;
    endcase
  endfunction
endpackage

FILE: rtl/vtesc_front.sv
// Front end: parse state machine, parameter collector and command decode
`timescale 1ns / 1ps
module vtesc_front #(
  parameter int PARAM_DEPTH = vtesc_pkg::PARAM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic              operation,
  input  logic [7:0]        byte_in,
  input  logic              mode_value,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              q_full,
  input  logic              done_params,
  output logic              ready,
  output logic              push,
  output vtesc_pkg::desc_t  desc,
  output vtesc_pkg::wr_t    wr
);
  import vtesc_pkg::*;
  localparam int CW = $clog2(PARAM_DEPTH + 1);

  ps_t          ps, ps_next;
  logic         ansi_mode, ansi_mode_next;
  logic         mode_rst;
  logic [CW-1:0] cnt, cnt_next;
  logic [15:0]  cur, cur_next;
  logic [1:0]   pend;
  logic         withp;
  logic [5:0]   c;
  logic [7:0]   cs;
  logic [15:0]  base;
  logic [19:0]  acc10;
  logic [5:0]   cnt6;
  logic         full;

  // no new item while the queue is full or a command with parameters still reads the store
  assign ready = !q_full && (pend == 2'd0);
  assign full  = ({1'b0, cnt} >= (CW + 1)'(PARAM_DEPTH));
  assign cnt6  = 6'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= PS_GROUND;
      ansi_mode <= 1'b1;
      mode_rst <= 1'b1;
      cnt <= '0;
      pend <= '0;
    end else begin
      ps <= ps_next;
      ansi_mode <= ansi_mode_next;
      cnt <= cnt_next;
      if (cfg_we) mode_rst <= cfg_data;
      pend <= pend + 2'(push && (desc.n != 5'd0)) - 2'(done_params);
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // decode of one accepted item
  always_comb begin
    ps_next = ps;
    ansi_mode_next = ansi_mode;
    cnt_next = cnt;
    cur_next = cur;
    wr = '0;
    push = 1'b0;
    withp = 1'b0;
    desc.cmd = CMD_PRINT;
    desc.arg = '0;
    c = CMD_NONE;
    cs = CS_NONE;
    base = (cnt == '0) ? 16'd0 : cur;
    acc10 = {1'b0, base, 3'b0} + {3'b0, base, 1'b0} + {12'b0, byte_in - CH_0};
    if (acc) begin
      if (operation == OP_MODE) begin
        ansi_mode_next = mode_value;
      end else if (byte_in < CH_SPACE) begin
        if (byte_in == CH_ESC) begin
          ps_next = PS_ESC;
          cnt_next = '0;
        end else if (byte_in == CH_CAN || byte_in == CH_SUB) begin
          ps_next = PS_GROUND;
          push = 1'b1;
          desc.arg = CH_ABORT_GLYPH;
        end else begin
          c = ctrl_cmd(byte_in);
          push = (c != CMD_NONE);
          desc.cmd = c;
        end
      end else if (byte_in != CH_DEL) begin
        case (ps)
          PS_ESC: begin
            ps_next = PS_GROUND;
            if (ansi_mode) begin
              case (byte_in)
                "[": ps_next = PS_CSI;
                "#": ps_next = PS_HASH;
                "(": ps_next = PS_G0;
                ")": ps_next = PS_G1;
                "O": ps_next = PS_ESCO;
                default: begin
                  c = esc_ansi_cmd(byte_in);
                  if (c == CMD_RIS) ansi_mode_next = mode_rst;
                end
              endcase
            end else if (byte_in == "Y") begin
              ps_next = PS_CDA;
            end else begin
              c = esc_vt52_cmd(byte_in);
              if (c == CMD_ANSI) ansi_mode_next = 1'b1;
            end
            push = (c != CMD_NONE);
            withp = 1'b1;
            desc.cmd = c;
          end
          PS_CSI, PS_CSIQ: begin
            if (ps == PS_CSI) begin
              c = csi_cmd(byte_in);
            end else begin
              c = (byte_in == "l") ? CMD_PRM : (byte_in == "h") ? CMD_PSM : CMD_NONE;
            end
            if (ps == PS_CSI && byte_in == CH_Q) begin
              ps_next = PS_CSIQ;
            end else if (c != CMD_NONE) begin
              ps_next = PS_GROUND;
              push = 1'b1;
              withp = 1'b1;
              desc.cmd = c;
            end else if (!full) begin
              // parameter collector
              if (byte_in == CH_SEMI) begin
                wr.we = 1'b1;
                wr.addr = 5'(cnt);
                cnt_next = cnt + 1'b1;
                cur_next = '0;
              end else if (byte_in >= CH_0 && byte_in <= CH_9) begin
                cur_next = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
                wr.we = 1'b1;
                wr.data = cur_next;
                if (cnt == '0) begin
                  cnt_next = CW'(1);
                end else begin
                  wr.addr = 5'(cnt - 1'b1);
                end
              end
            end
          end
          PS_HASH: begin
            ps_next = PS_GROUND;
            c = hash_cmd(byte_in);
            push = (c != CMD_NONE);
            withp = 1'b1;
            desc.cmd = c;
          end
          PS_G0, PS_G1: begin
            ps_next = PS_GROUND;
            cs = charset_num(byte_in);
            push = (cs != CS_NONE);
            withp = 1'b1;
            desc.cmd = (ps == PS_G0) ? CMD_G0 : CMD_G1;
            desc.arg = cs;
          end
          PS_ESCO: begin
            ps_next = PS_GROUND;
            push = 1'b1;
            withp = 1'b1;
            if (byte_in >= "A" && byte_in <= "D") begin
              desc.cmd = CMD_CUU + 6'(byte_in - "A");
            end else begin
              desc.arg = byte_in;
            end
          end
          PS_CDA: begin
            if (!full) begin
              wr.we = 1'b1;
              wr.addr = 5'(cnt);
              wr.data = 16'(byte_in) - 16'd31;
              cur_next = wr.data;
              cnt_next = cnt + 1'b1;
            end
            if (6'(cnt_next) >= 6'd2) begin
              ps_next = PS_GROUND;
              push = 1'b1;
              withp = 1'b1;
              desc.cmd = CMD_CUP;
            end
          end
          default: begin
            ps_next = PS_GROUND;
            push = 1'b1;
            desc.arg = byte_in;
          end
        endcase
      end
    end
    if (withp) begin
      desc.n = (cnt6 > 6'(OUT_PARAMS_MAX)) ? 5'(OUT_PARAMS_MAX) : 5'(cnt6);
    end else begin
      desc.n = '0;
    end
  end
endmodule

FILE: rtl/vtesc_fifo.sv
// Two-entry command queue between front end and back end
`timescale 1ns / 1ps
module vtesc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vtesc_pkg::desc_t din,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output vtesc_pkg::desc_t dout
);
  import vtesc_pkg::*;

  desc_t      mem [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end
endmodule

FILE: rtl/vtesc_back.sv
// Back end: parameter store and result sequencer with output register
`timescale 1ns / 1ps
module vtesc_back #(
  parameter int PARAM_DEPTH = vtesc_pkg::PARAM_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  vtesc_pkg::wr_t   wr,
  input  logic             q_empty,
  input  vtesc_pkg::desc_t q_dout,
  output logic             pop,
  output logic             done_params,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [39:0]      out_data,
  output logic             out_user,
  output logic             out_last
);
  import vtesc_pkg::*;
  `include "vt100_escape_sequence_parser_core_assert.svh"
  localparam int IW = $clog2(PARAM_DEPTH);

  logic [15:0] store [PARAM_DEPTH];
  bk_state_t   st, st_next;
  desc_t       cur;
  logic [4:0]  idx;
  logic [15:0] rd_data;
  logic        rd_vld;
  logic        load, adv;
  logic [5:0]  o_cmd;
  logic [7:0]  o_arg;
  logic [4:0]  o_cnt;
  logic [3:0]  o_idx;
  logic [15:0] o_val;

  assign load = !out_valid || out_ready;
  assign out_data = {1'b0, o_val, o_idx, o_cnt, o_arg, o_cmd};

  // parameter store, registered read
  always_ff @(posedge clk) begin
    if (wr.we) store[wr.addr[IW-1:0]] <= wr.data;
    rd_data <= store[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      idx <= '0;
    end else begin
      st <= st_next;
      rd_vld <= !(pop || adv);
      if (pop || adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) idx <= '0;
      else if (adv) idx <= idx + 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_dout;
      o_cmd <= q_dout.cmd;
      o_arg <= q_dout.arg;
      o_cnt <= q_dout.n;
      o_idx <= '0;
      o_val <= '0;
      out_user <= 1'b0;
      out_last <= (q_dout.n == 5'd0);
    end else if (adv) begin
      o_idx <= idx[3:0];
      o_val <= rd_data;
      out_user <= 1'b1;
      out_last <= (idx + 1'b1 == cur.n);
    end
  end

  // sequencer
  always_comb begin
    st_next = st;
    pop = 1'b0;
    adv = 1'b0;
    done_params = 1'b0;
    case (st)
      BK_IDLE: begin
        if (load && !q_empty) begin
          pop = 1'b1;
          if (q_dout.n != 5'd0) st_next = BK_BUSY;
        end
      end
      BK_BUSY: begin
        if (load && rd_vld) begin
          adv = 1'b1;
          if (idx + 1'b1 == cur.n) begin
            st_next = BK_IDLE;
            done_params = 1'b1;
          end
        end
      end
      default: st_next = BK_IDLE;
    endcase
  end

  `VTESC_ASSERT(a_idx_range, clk, rst, (out_valid && out_user) |-> (5'(o_idx) < o_cnt))
  `VTESC_ASSERT(a_cmd_last, clk, rst, (out_valid && !out_user) |-> (out_last == (o_cnt == 5'd0)))
  `VTESC_ASSERT(a_busy_n, clk, rst, (st == BK_BUSY) |-> (cur.n != 5'd0 && idx < cur.n))
  `VTESC_ASSERT_NEXT(a_done_idle, clk, rst, done_params, st == BK_IDLE)
endmodule

FILE: rtl/vt100_escape_sequence_parser_core.sv
// Top level of the VT100/VT52 escape sequence parser
// A command result passes the command queue and then the output register; each parameter
// result follows the previous result after a registered read of the parameter store.
// Throughput: one input item per cycle if the queue has room; after a command with
// parameters, input stalls until its last parameter result is loaded, as the store is shared.
// Reset: synchronous active-high; ground state, ANSI mode, empty parameter list, empty queue.
`timescale 1ns / 1ps
module vt100_escape_sequence_parser_core #(
  parameter int PARAM_DEPTH = vtesc_pkg::PARAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_in[7:0], mode_value[8], zero pad
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // command[5:0], argument[13:6], param_count[18:14],
                                      // param_index[22:19], param_value[38:23], zero pad
  output logic        m_axis_tuser,   // is_param
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data        // ansi_mode_at_reset
);
  import vtesc_pkg::*;

  logic  acc, f_ready, push, q_full, q_empty, pop, done_params;
  desc_t desc, q_dout;
  wr_t   wr;

  assign s_axis_tready = f_ready;
  assign acc = s_axis_tvalid && f_ready;
  assign cfg_ready = 1'b1;

  vtesc_front #(.PARAM_DEPTH(PARAM_DEPTH)) u_front (
    .clk(clk), .rst(rst), .acc(acc), .operation(s_axis_tuser),
    .byte_in(s_axis_tdata[7:0]), .mode_value(s_axis_tdata[8]),
    .cfg_we(cfg_valid), .cfg_data(cfg_data), .q_full(q_full),
    .done_params(done_params), .ready(f_ready), .push(push), .desc(desc), .wr(wr)
  );

  vtesc_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .din(desc), .pop(pop),
    .full(q_full), .empty(q_empty), .dout(q_dout)
  );

  vtesc_back #(.PARAM_DEPTH(PARAM_DEPTH)) u_back (
    .clk(clk), .rst(rst), .wr(wr), .q_empty(q_empty), .q_dout(q_dout), .pop(pop),
    .done_params(done_params), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast)
  );
endmodule
